>>> design/lmsr_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix shadow refresh package
// Shared types and constants for the shadow image and its refresh engine.
// ----------------------------------------------------------------------------
package lmsr_pkg;

  // Matrix geometry and queue sizing defaults.
  localparam int NumRowsDefault    = 8;
  localparam int QueueDepthDefault = 2;

  // Fixed-address command byte, the row index is OR-ed into the low bits.
  localparam logic [7:0] AddrCmd      = 8'hC0;
  // Pattern forced into the active copy by a clear, so every row is rewritten.
  localparam logic [7:0] ForceRow     = 8'hFF;
  localparam logic [7:0] HoldoffReset = 8'd2;
  localparam logic [7:0] MsMax        = 8'hFF;

  // Input request function codes.
  localparam logic [1:0] FuncSet   = 2'd0;
  localparam logic [1:0] FuncClear = 2'd1;
  localparam logic [1:0] FuncTick  = 2'd2;

  // Configuration register indexes.
  localparam logic CfgEnable  = 1'b0;
  localparam logic CfgHoldoff = 1'b1;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLEAR,
    OP_TICK
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [2:0] row;
    logic [2:0] col;
    logic       led_on;
  } cmd_t;

  typedef struct packed {
    logic [7:0] addr_byte;
    logic [7:0] data_byte;
    logic       last;
  } frame_t;

  typedef enum logic {
    BK_IDLE,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    logic flushing;
    logic diff_any;
  } back_status_t;

endpackage

>>> design/lmsr_fifo.sv
// ----------------------------------------------------------------------------
// LMSR request queue
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lmsr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> design/lmsr_front.sv
// ----------------------------------------------------------------------------
// LMSR front end
// Decodes incoming requests, drops those with no effect and queues the rest.
// ----------------------------------------------------------------------------
module lmsr_front import lmsr_pkg::*; #(
  parameter int NumRows    = NumRowsDefault,
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] func_i,
  input  logic [2:0] row_i,
  input  logic [2:0] col_i,
  input  logic       led_on_i,
  input  logic       enable_i,
  input  logic       cmd_pop_i,
  output cmd_t       cmd_o,
  output logic       cmd_empty_o
);

  cmd_t cmd;
  logic keep;
  logic row_ok;

  assign row_ok = (int'(row_i) < NumRows);

  always_comb begin
    cmd.row    = row_i;
    cmd.col    = col_i;
    cmd.led_on = led_on_i;
    cmd.op     = OP_TICK;
    keep       = 1'b0;
    unique case (func_i)
      FuncSet: begin
        // A set request while disabled or outside the matrix changes nothing.
        cmd.op = OP_SET;
        keep   = enable_i && row_ok;
      end
      FuncClear: begin
        cmd.op = OP_CLEAR;
        keep   = 1'b1;
      end
      FuncTick: begin
        cmd.op = OP_TICK;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  lmsr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .wdata_i (cmd),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .full_o  (full_o),
    .empty_o (cmd_empty_o)
  );

endmodule

>>> design/lmsr_back.sv
// ----------------------------------------------------------------------------
// LMSR back end
// Holds the shadow and active images, the holdoff timer and the flush engine.
// ----------------------------------------------------------------------------
module lmsr_back import lmsr_pkg::*; #(
  parameter int NumRows = NumRowsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   holdoff_i,
  input  cmd_t         cmd_i,
  input  logic         cmd_empty_i,
  output logic         cmd_pop_o,
  output frame_t       frame_o,
  output logic         frame_push_o,
  input  logic         frame_full_i,
  output back_status_t status_o
);

  localparam int RowW = (NumRows > 1) ? $clog2(NumRows) : 1;

  back_state_e state_q, state_d;

  logic [7:0]   shadow_q [NumRows];
  logic [7:0]   shadow_d [NumRows];
  logic [7:0]   active_q [NumRows];
  logic [7:0]   active_d [NumRows];
  logic         pending_q, pending_d;
  logic [7:0]   ms_q, ms_d;

  logic [NumRows-1:0] diff;
  logic               diff_any;
  logic [RowW-1:0]    sel;
  logic [7:0]         ms_inc;
  logic               flush_go;
  logic               set_chg;
  logic [7:0]         bit_mask;

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      diff[r] = (shadow_q[r] != active_q[r]);
    end
  end

  assign diff_any = |diff;

  // Lowest differing row goes out first.
  always_comb begin
    sel = '0;
    for (int r = NumRows - 1; r >= 0; r--) begin
      if (diff[r]) begin
        sel = RowW'(r);
      end
    end
  end

  assign ms_inc   = (ms_q == MsMax) ? ms_q : ms_q + 8'd1;
  assign flush_go = pending_q && (ms_inc >= holdoff_i);
  assign bit_mask = 8'd1 << cmd_i.col;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i && cmd_i.op == OP_TICK && flush_go) begin
          state_d = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!diff_any) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_pop_o    = 1'b0;
    frame_push_o = 1'b0;
    unique case (state_q)
      BK_IDLE:  cmd_pop_o    = !cmd_empty_i;
      BK_FLUSH: frame_push_o = diff_any && !frame_full_i;
      default: begin
        cmd_pop_o    = 1'b0;
        frame_push_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    frame_o.addr_byte = AddrCmd | 8'(sel);
    frame_o.data_byte = shadow_q[sel];
    // The frame is the last one when a single row still differs.
    frame_o.last      = ((diff & (diff - NumRows'(1))) == '0);
  end

  assign status_o.flushing = (state_q == BK_FLUSH);
  assign status_o.diff_any = diff_any;

  // Image and timer updates.
  always_comb begin
    shadow_d  = shadow_q;
    active_d  = active_q;
    pending_d = pending_q;
    ms_d      = ms_q;
    set_chg   = 1'b0;
    if (cmd_pop_o) begin
      unique case (cmd_i.op)
        OP_SET: begin
          for (int r = 0; r < NumRows; r++) begin
            if (int'(cmd_i.row) == r) begin
              shadow_d[r] = cmd_i.led_on ? (shadow_q[r] | bit_mask)
                                         : (shadow_q[r] & ~bit_mask);
            end
            set_chg = set_chg || (shadow_d[r] != shadow_q[r]);
          end
          if (set_chg) begin
            pending_d = 1'b1;
            ms_d      = '0;
          end
        end
        OP_CLEAR: begin
          for (int r = 0; r < NumRows; r++) begin
            shadow_d[r] = '0;
            active_d[r] = ForceRow;
          end
          pending_d = 1'b1;
          ms_d      = '0;
        end
        OP_TICK: begin
          ms_d = ms_inc;
          if (flush_go) begin
            pending_d = 1'b0;
          end
        end
        default: begin
          pending_d = pending_q;
        end
      endcase
    end
    if (frame_push_o) begin
      active_d[sel] = shadow_q[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      pending_q <= 1'b0;
      ms_q      <= '0;
      for (int r = 0; r < NumRows; r++) begin
        shadow_q[r] <= '0;
        active_q[r] <= '0;
      end
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      ms_q      <= ms_d;
      shadow_q  <= shadow_d;
      active_q  <= active_d;
    end
  end

endmodule

>>> design/led_matrix_shadow_refresh.sv
// A tick that starts a flush is taken from the request queue by the idle back
// end, which enters the flush state and pushes frames into the result queue.
// Set, clear and tick requests are taken only while the back end is idle;
// a flush sends one frame per differing row, stalling on a full result queue.
// Reset clears both images, the pending mark and the timer at once;
// enable resets to one and holdoff to two milliseconds.
// ----------------------------------------------------------------------------
// LED matrix shadow refresh
// Shadow LED image with deferred, difference-only refresh of the display.
// ----------------------------------------------------------------------------
module led_matrix_shadow_refresh import lmsr_pkg::*; #(
  parameter int NumRows    = NumRowsDefault,
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func_i,
  input  logic [2:0] row_i,
  input  logic [2:0] col_i,
  input  logic       led_on_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] addr_byte_o,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i
);

  logic         enable_q;
  logic [7:0]   holdoff_q;
  cmd_t         cmd;
  logic         cmd_empty;
  logic         cmd_pop;
  frame_t       frame;
  frame_t       frame_out;
  logic         frame_push;
  logic         frame_full;
  back_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      holdoff_q <= HoldoffReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgEnable:  enable_q  <= cfg_wdata_i[0];
        CfgHoldoff: holdoff_q <= cfg_wdata_i;
        default:    enable_q  <= enable_q;
      endcase
    end
  end

  lmsr_front #(
    .NumRows    (NumRows),
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .led_on_i    (led_on_i),
    .enable_i    (enable_q),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  lmsr_back #(
    .NumRows (NumRows)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .holdoff_i    (holdoff_q),
    .cmd_i        (cmd),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .frame_o      (frame),
    .frame_push_o (frame_push),
    .frame_full_i (frame_full),
    .status_o     (status)
  );

  lmsr_fifo #(
    .Width ($bits(frame_t)),
    .Depth (QueueDepth)
  ) u_frame_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_push),
    .wdata_i (frame),
    .pop_i   (pop),
    .rdata_o (frame_out),
    .full_o  (frame_full),
    .empty_o (empty)
  );

  assign addr_byte_o = frame_out.addr_byte;
  assign data_byte_o = frame_out.data_byte;
  assign last_o      = frame_out.last;

`ifndef ASSERT_OFF
  // The back end never offers a frame to a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(frame_push && frame_full))
    else $error("frame pushed into full result queue");

  // After the last frame of a flush no row differs any more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_push && frame.last) |=> !status.diff_any)
    else $error("rows still differ after last frame");

  // No request is taken while a flush is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.flushing |-> !cmd_pop)
    else $error("request taken during flush");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix shadow refresh testbench
// Drives set, clear, tick and unused requests with random idling on both
// sides. A scoreboard class predicts the shadow and active images and
// checks every refresh frame against the oldest expected frame.
// ----------------------------------------------------------------------------
import lmsr_pkg::*;

class flush_scoreboard;
  logic [7:0] shadow_img [NumRowsDefault];
  logic [7:0] active_img [NumRowsDefault];
  logic       flush_pending;
  logic [7:0] ms_count;
  logic       led_enable;
  logic [7:0] holdoff;
  frame_t     frames_due [$];
  int         mismatches;

  function new();
    foreach (shadow_img[i]) begin
      shadow_img[i] = '0;
      active_img[i] = '0;
    end
    flush_pending = 1'b0;
    ms_count      = '0;
    led_enable    = 1'b1;
    holdoff       = HoldoffReset;
    mismatches    = 0;
  endfunction

  function void set_reg(logic idx, logic [7:0] val);
    if (idx == CfgEnable) begin
      led_enable = val[0];
    end else begin
      holdoff = val;
    end
  endfunction

  function int outstanding();
    return frames_due.size();
  endfunction

  function void note_mismatch(string msg);
    if (mismatches < 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endfunction

  // Updates the images for one accepted request and queues the frames it causes.
  function void note_request(logic [1:0] func, logic [2:0] row, logic [2:0] col,
                             logic on);
    logic [7:0] updated;
    int         last_row;
    frame_t     fr;
    case (func)
      FuncSet: begin
        if (led_enable) begin
          updated      = shadow_img[row];
          updated[col] = on;
          if (updated != shadow_img[row]) begin
            shadow_img[row] = updated;
            flush_pending   = 1'b1;
            ms_count        = '0;
          end
        end
      end
      FuncClear: begin
        foreach (shadow_img[i]) begin
          shadow_img[i] = '0;
          active_img[i] = ForceRow;
        end
        flush_pending = 1'b1;
        ms_count      = '0;
      end
      FuncTick: begin
        if (ms_count != MsMax) begin
          ms_count = ms_count + 8'd1;
        end
        if (flush_pending && ms_count >= holdoff) begin
          last_row = -1;
          for (int r = 0; r < NumRowsDefault; r++) begin
            if (shadow_img[r] != active_img[r]) last_row = r;
          end
          for (int r = 0; r < NumRowsDefault; r++) begin
            if (shadow_img[r] != active_img[r]) begin
              fr.addr_byte  = AddrCmd | 8'(r);
              fr.data_byte  = shadow_img[r];
              fr.last       = (r == last_row);
              frames_due.push_back(fr);
              active_img[r] = shadow_img[r];
            end
          end
          flush_pending = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function void check_frame(logic [7:0] addr, logic [7:0] data, logic last);
    frame_t want;
    if (frames_due.size() == 0) begin
      note_mismatch($sformatf("unexpected frame addr %02h data %02h last %0b",
                              addr, data, last));
      return;
    end
    want = frames_due.pop_front();
    if (want.addr_byte !== addr || want.data_byte !== data || want.last !== last) begin
      note_mismatch($sformatf("expected addr %02h data %02h last %0b, got %02h %02h %0b",
                              want.addr_byte, want.data_byte, want.last,
                              addr, data, last));
    end
  endfunction
endclass

module tb;
  localparam logic [1:0] FuncUnused = 2'd3;
  // Cycles allowed for requests that cause no frame to leave the block.
  localparam int IdleTail = 30;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [1:0] func_i;
  logic [2:0] row_i;
  logic [2:0] col_i;
  logic       led_on_i;
  logic       empty;
  logic       pop;
  logic [7:0] addr_byte_o;
  logic [7:0] data_byte_o;
  logic       last_o;
  logic       cfg_we_i;
  logic       cfg_addr_i;
  logic [7:0] cfg_wdata_i;

  flush_scoreboard sb = new();
  bit push_held;
  int send_gap_pct  = 30;
  int pop_stall_pct = 30;

  led_matrix_shadow_refresh u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .led_on_i   (led_on_i),
    .empty      (empty),
    .pop        (pop),
    .addr_byte_o(addr_byte_o),
    .data_byte_o(data_byte_o),
    .last_o     (last_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(int pct);
    if (int'($urandom_range(0, 99)) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(12, 40));
    return int'($urandom_range(1, 3));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_request(func_i, row_i, col_i, led_on_i);
    if (rst_ni && pop && !empty) sb.check_frame(addr_byte_o, data_byte_o, last_o);
  end

  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap(pop_stall_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Holds the request until the block takes it; returns at the accepting edge.
  task automatic send_req(logic [1:0] f, logic [2:0] r, logic [2:0] c, logic on);
    push      <= 1'b1;
    func_i    <= f;
    row_i     <= r;
    col_i     <= c;
    led_on_i  <= on;
    push_held = 1'b1;
    do @(posedge clk_i); while (full);
  endtask

  task automatic issue(logic [1:0] f, logic [2:0] r, logic [2:0] c, logic on);
    int g;
    send_req(f, r, c, on);
    g = pick_gap(send_gap_pct);
    if (g > 0) begin
      push      <= 1'b0;
      push_held = 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic tick_n(int n);
    repeat (n) issue(FuncTick, 3'($urandom), 3'($urandom), 1'($urandom));
  endtask

  // Stops sending and waits until every expected frame has been popped.
  task automatic settle();
    if (push_held) begin
      push      <= 1'b0;
      push_held = 1'b0;
    end
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic configure(logic en, logic [7:0] hold);
    settle();
    write_reg(CfgEnable, {7'd0, en});
    write_reg(CfgHoldoff, hold);
  endtask

  // Bursts of LED changes followed mostly by enough ticks to flush them.
  task automatic run_bursts(int n_items);
    int done;
    int roll;
    int t;
    done = 0;
    while (done < n_items) begin
      repeat ($urandom_range(1, 6)) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 5) begin
          issue(FuncClear, 3'($urandom), 3'($urandom), 1'($urandom));
          done++;
        end else if (roll < 10) begin
          issue(FuncUnused, 3'($urandom), 3'($urandom), 1'($urandom));
        end else begin
          issue(FuncSet, 3'($urandom), 3'($urandom), 1'($urandom));
          done++;
        end
      end
      if ($urandom_range(0, 99) < 80) begin
        t = int'(sb.holdoff) + int'($urandom_range(0, 2));
      end else begin
        t = int'($urandom_range(0, sb.holdoff));
      end
      tick_n(t);
      done += t;
    end
  endtask

  initial begin
    logic       en_pick;
    logic [7:0] hold_pick;
    push        <= 1'b0;
    push_held   = 1'b0;
    func_i      <= FuncSet;
    row_i       <= '0;
    col_i       <= '0;
    led_on_i    <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= CfgEnable;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: enabled, two ticks of holdoff.
    issue(FuncSet, 3'd0, 3'd0, 1'b1);
    issue(FuncSet, 3'd0, 3'd0, 1'b1);
    issue(FuncSet, 3'd7, 3'd7, 1'b1);
    tick_n(3);
    // A change undone before the flush leaves nothing to send.
    issue(FuncSet, 3'd3, 3'd5, 1'b1);
    issue(FuncSet, 3'd3, 3'd5, 1'b0);
    tick_n(2);
    issue(FuncUnused, 3'd7, 3'd7, 1'b1);
    issue(FuncClear, 3'd0, 3'd0, 1'b0);
    tick_n(2);

    configure(1'b1, 8'd0);
    issue(FuncSet, 3'd1, 3'd3, 1'b1);
    tick_n(1);
    configure(1'b0, 8'd0);
    issue(FuncSet, 3'd2, 3'd1, 1'b1);
    issue(FuncClear, 3'd5, 3'd2, 1'b1);
    tick_n(2);

    // Random phases with changing settings and idling.
    configure(1'b1, 8'd2);
    run_bursts(20);
    configure(1'b1, 8'd1);
    send_gap_pct  = 0;
    pop_stall_pct = 0;
    run_bursts(20);
    configure(1'b0, 8'd3);
    send_gap_pct  = 60;
    pop_stall_pct = 40;
    run_bursts(20);
    configure(1'b1, 8'd0);
    send_gap_pct  = 30;
    pop_stall_pct = 70;
    run_bursts(10);
    settle();
    run_bursts(10);
    configure(1'b1, 8'd5);
    send_gap_pct  = 40;
    pop_stall_pct = 20;
    run_bursts(20);

    // Long holdoff: the flush waits for the full count of ticks.
    configure(1'b1, 8'd40);
    issue(FuncSet, 3'd6, 3'd4, 1'b1);
    issue(FuncSet, 3'd2, 3'd6, 1'b1);
    tick_n(41);
    issue(FuncSet, 3'd6, 3'd4, 1'b0);
    tick_n(2);

    en_pick   = 1'($urandom);
    hold_pick = 8'($urandom_range(0, 6));
    configure(en_pick, hold_pick);
    run_bursts(20);

    settle();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> led_matrix_shadow_refresh.f
design/lmsr_pkg.sv
design/lmsr_fifo.sv
design/lmsr_front.sv
design/lmsr_back.sv
design/led_matrix_shadow_refresh.sv
dv/tb.sv
